// ===== rtl/core/maze_floodfill_distance_update_assert.svh =====
// Assertion macros for the maze flood-fill distance block.
// Each macro takes a label, an antecedent and a consequent; clock and
// reset are the block's own.
`ifndef MAZE_FLOODFILL_DISTANCE_UPDATE_ASSERT_SVH
`define MAZE_FLOODFILL_DISTANCE_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFDU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mfdu assertion failed");
`define MFDU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mfdu assertion failed");
`else
`define MFDU_ASSERT_SAME(label, ante, cons)
`define MFDU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/mfdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdu_pkg
// Types, codes and the reset-map function shared by the flood-fill block.
// ----------------------------------------------------------------------------
package mfdu_pkg;

   localparam int COORD_W = 4;
   localparam int DIST_W = 8;
   localparam int CHG_W = 16;
   localparam int POPS_W = 20;
   localparam logic [POPS_W-1:0] FLOOD_POP_LIMIT = 20'd1000000;
   localparam logic [DIST_W-1:0] DIST_MAX = 8'd255;
   localparam logic [CHG_W-1:0] CHG_MAX = 16'hffff;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic [1:0] ADDR_REQ = 2'd0;
   localparam logic [1:0] ADDR_CUR = 2'd1;
   localparam logic [1:0] ADDR_NB = 2'd2;

   // neighbour order: top, right, bottom, left
   localparam logic [1:0] NB_TOP = 2'd0;
   localparam logic [1:0] NB_RIGHT = 2'd1;
   localparam logic [1:0] NB_BOTTOM = 2'd2;
   localparam logic [1:0] NB_LEFT = 2'd3;

   typedef struct packed {
      logic mode;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
      logic add_top_wall;
      logic add_right_wall;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] cell_dist;
      logic cell_top;
      logic cell_right;
      logic [CHG_W-1:0] cells_changed;
      logic overflow;
   } rsp_type;

   typedef struct packed {
      logic top;
      logic right;
      logic [DIST_W-1:0] distance;
   } cell_type;

   typedef struct packed {
      logic load_req;
      logic cell_rd;
      logic [1:0] addr_sel;
      logic cap_own;
      logic cap_nb;
      logic seed_wr;
      logic pop;
      logic abort;
      logic load_cur;
      logic upd_wr;
      logic push;
      logic nb_clr;
      logic nb_inc;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic sp_zero;
      logic pop_limit;
      logic cur_centre;
      logic nb_last;
      logic upd_needed;
      logic mode;
      logic oob;
      logic rsp_busy;
   } sts_type;

   function automatic logic [COORD_W:0] absdiff(input logic [COORD_W:0] a,
                                                input logic [COORD_W:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Map contents straight after reset
   function automatic cell_type reset_cell(input logic [COORD_W-1:0] r,
                                           input logic [COORD_W-1:0] c,
                                           input logic [COORD_W:0] side);
      logic [COORD_W:0] g1;
      logic [COORD_W:0] g2;
      logic [COORD_W:0] rr;
      logic [COORD_W:0] cc;
      logic [COORD_W+1:0] d;
      logic [COORD_W+1:0] t;
      cell_type res;
      g1 = side >> 1;
      g2 = g1 - 1'b1;
      rr = {1'b0, r};
      cc = {1'b0, c};
      d = {1'b0, absdiff(rr, g1)} + {1'b0, absdiff(cc, g1)};
      t = {1'b0, absdiff(rr, g1)} + {1'b0, absdiff(cc, g2)};
      if (t < d) d = t;
      t = {1'b0, absdiff(rr, g2)} + {1'b0, absdiff(cc, g1)};
      if (t < d) d = t;
      t = {1'b0, absdiff(rr, g2)} + {1'b0, absdiff(cc, g2)};
      if (t < d) d = t;
      res.distance = DIST_W'(d);
      res.top = (rr == side - 1'b1);
      res.right = (cc == side - 1'b1) || (c == '0 && r <= COORD_W'(2));
      return res;
   endfunction

endpackage

// ===== rtl/core/mfdu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfdu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mfdu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdu_ctrl
// Sequencer for request intake, the flood loop and the response hand-off.
// ----------------------------------------------------------------------------
module mfdu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mfdu_pkg::sts_type sts,
   output mfdu_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_SEED = 4'd2;
   localparam logic [3:0] S_POP = 4'd3;
   localparam logic [3:0] S_LOAD = 4'd4;
   localparam logic [3:0] S_CHK = 4'd5;
   localparam logic [3:0] S_OWN = 4'd6;
   localparam logic [3:0] S_NRD = 4'd7;
   localparam logic [3:0] S_NCAP = 4'd8;
   localparam logic [3:0] S_EVAL = 4'd9;
   localparam logic [3:0] S_PUSH = 4'd10;
   localparam logic [3:0] S_RESP = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            if (sts.oob) begin
               state_in = S_RESP;
            end else begin
               cmd.cell_rd = 1'b1;
               cmd.addr_sel = mfdu_pkg::ADDR_REQ;
               state_in = (sts.mode == mfdu_pkg::MODE_READ) ? S_RESP : S_SEED;
            end
         end
         S_SEED: begin
            cmd.seed_wr = 1'b1;
            state_in = S_POP;
         end
         S_POP: begin
            if (sts.sp_zero || sts.pop_limit) begin
               cmd.abort = sts.pop_limit && !sts.sp_zero;
               cmd.cell_rd = 1'b1;
               cmd.addr_sel = mfdu_pkg::ADDR_REQ;
               state_in = S_RESP;
            end else begin
               cmd.pop = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_cur = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.cur_centre) begin
               state_in = S_POP;
            end else begin
               cmd.cell_rd = 1'b1;
               cmd.addr_sel = mfdu_pkg::ADDR_CUR;
               cmd.nb_clr = 1'b1;
               state_in = S_OWN;
            end
         end
         S_OWN: begin
            cmd.cap_own = 1'b1;
            state_in = S_NRD;
         end
         S_NRD: begin
            cmd.cell_rd = 1'b1;
            cmd.addr_sel = mfdu_pkg::ADDR_NB;
            state_in = S_NCAP;
         end
         S_NCAP: begin
            cmd.cap_nb = 1'b1;
            if (sts.nb_last) begin
               state_in = S_EVAL;
            end else begin
               cmd.nb_inc = 1'b1;
               state_in = S_NRD;
            end
         end
         S_EVAL: begin
            if (sts.upd_needed) begin
               cmd.upd_wr = 1'b1;
               cmd.nb_clr = 1'b1;
               state_in = S_PUSH;
            end else begin
               state_in = S_POP;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            if (sts.nb_last) begin
               state_in = S_POP;
            end else begin
               cmd.nb_inc = 1'b1;
            end
         end
         S_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/mfdu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdu_dp
// Datapath: maze map and pending-cell stack memories, neighbour scan,
// counters and the response register.
// ----------------------------------------------------------------------------
module mfdu_dp #(
   parameter int MAZE_SIDE = 16,
   parameter int STACK_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  mfdu_pkg::req_type req_data,
   input  mfdu_pkg::cmd_type cmd,
   output mfdu_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mfdu_pkg::rsp_type rsp_data
);

   localparam int CW = mfdu_pkg::COORD_W;
   localparam int CELLS = MAZE_SIDE * MAZE_SIDE;
   localparam int CAW = $clog2(CELLS);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int CELL_W = $bits(mfdu_pkg::cell_type);
   localparam logic [CW-1:0] LAST = CW'(MAZE_SIDE - 1);
   localparam logic [CW-1:0] CTR_HI = CW'(MAZE_SIDE / 2);
   localparam logic [CW-1:0] CTR_LO = CW'((MAZE_SIDE - 1) / 2);
   localparam logic [CW:0] SIDE = (CW + 1)'(MAZE_SIDE);
   localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

   function automatic logic [CAW-1:0] cell_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
      logic [7:0] lin;
      lin = 8'(r * 8'(MAZE_SIDE)) + 8'(c);
      return lin[CAW-1:0];
   endfunction

   function automatic logic is_centre(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return (r == CTR_HI || r == CTR_LO) && (c == CTR_HI || c == CTR_LO);
   endfunction

   mfdu_pkg::req_type req_ff;
   logic [CW-1:0] cur_r_ff, cur_c_ff;
   logic own_top_ff, own_right_ff;
   logic [7:0] own_dist_ff;
   logic [7:0] mn_ff;
   logic open_ff;
   logic [1:0] nb_ff;
   logic [SPW-1:0] sp_ff;
   logic [mfdu_pkg::POPS_W-1:0] pops_ff;
   logic [mfdu_pkg::CHG_W-1:0] changed_ff;
   logic ovf_ff;
   logic [CELLS-1:0] valid_ff;
   logic rd_valid_ff;
   logic [CW-1:0] rd_r_ff, rd_c_ff;
   logic rsp_valid_ff;
   mfdu_pkg::rsp_type rsp_ff;

   logic [CW-1:0] nb_r, nb_c;
   logic nb_in;
   logic nb_open;
   logic push_ok;
   logic [CW-1:0] rd_r, rd_c;
   logic [CW-1:0] wr_r, wr_c;
   logic cell_we;
   mfdu_pkg::cell_type cell_wd;
   logic [CELL_W-1:0] cell_q;
   mfdu_pkg::cell_type view;
   logic [7:0] nv;
   logic stk_we;
   logic [SAW-1:0] stk_wa;
   logic [2*CW-1:0] stk_wd;
   logic [2*CW-1:0] stk_q;
   logic [SPW-1:0] sp_dec;

   // neighbour coordinates and bounds for the current scan slot
   always_comb begin
      nb_r = cur_r_ff;
      nb_c = cur_c_ff;
      nb_in = 1'b0;
      nb_open = 1'b0;
      case (nb_ff)
         mfdu_pkg::NB_TOP: begin
            nb_r = cur_r_ff + 1'b1;
            nb_in = (cur_r_ff != LAST);
            nb_open = nb_in && !own_top_ff;
         end
         mfdu_pkg::NB_RIGHT: begin
            nb_c = cur_c_ff + 1'b1;
            nb_in = (cur_c_ff != LAST);
            nb_open = nb_in && !own_right_ff;
         end
         mfdu_pkg::NB_BOTTOM: begin
            nb_r = cur_r_ff - 1'b1;
            nb_in = (cur_r_ff != '0);
            nb_open = nb_in && !view.top;
         end
         default: begin
            nb_c = cur_c_ff - 1'b1;
            nb_in = (cur_c_ff != '0);
            nb_open = nb_in && !view.right;
         end
      endcase
   end

   always_comb begin
      case (cmd.addr_sel)
         mfdu_pkg::ADDR_REQ: begin
            rd_r = req_ff.row;
            rd_c = req_ff.column;
         end
         mfdu_pkg::ADDR_CUR: begin
            rd_r = cur_r_ff;
            rd_c = cur_c_ff;
         end
         default: begin
            rd_r = nb_r;
            rd_c = nb_c;
         end
      endcase
   end

   // unwritten cells read back as the reset map
   assign view = rd_valid_ff ? mfdu_pkg::cell_type'(cell_q)
                             : mfdu_pkg::reset_cell(rd_r_ff, rd_c_ff, SIDE);

   assign nv = (mn_ff == mfdu_pkg::DIST_MAX) ? mfdu_pkg::DIST_MAX : mn_ff + 1'b1;

   assign cell_we = cmd.seed_wr || cmd.upd_wr;
   always_comb begin
      if (cmd.seed_wr) begin
         wr_r = req_ff.row;
         wr_c = req_ff.column;
         cell_wd.top = view.top | req_ff.add_top_wall;
         cell_wd.right = view.right | req_ff.add_right_wall;
         cell_wd.distance = view.distance;
      end else begin
         wr_r = cur_r_ff;
         wr_c = cur_c_ff;
         cell_wd.top = own_top_ff;
         cell_wd.right = own_right_ff;
         cell_wd.distance = nv;
      end
   end

   mfdu_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_map (
      .clock  (clock),
      .wr_en  (cell_we),
      .wr_addr(cell_addr(wr_r, wr_c)),
      .wr_data(cell_wd),
      .rd_en  (cmd.cell_rd),
      .rd_addr(cell_addr(rd_r, rd_c)),
      .rd_data(cell_q)
   );

   assign push_ok = cmd.push && nb_in && !is_centre(nb_r, nb_c);
   assign sp_dec = sp_ff - 1'b1;
   assign stk_we = cmd.seed_wr || (push_ok && sp_ff != SP_FULL);
   assign stk_wa = cmd.seed_wr ? '0 : sp_ff[SAW-1:0];
   assign stk_wd = cmd.seed_wr ? {req_ff.row, req_ff.column} : {nb_r, nb_c};

   mfdu_ram #(.WIDTH(2 * CW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock  (clock),
      .wr_en  (stk_we),
      .wr_addr(stk_wa),
      .wr_data(stk_wd),
      .rd_en  (cmd.pop),
      .rd_addr(sp_dec[SAW-1:0]),
      .rd_data(stk_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         sp_ff <= '0;
         rsp_valid_ff <= 1'b0;
         nb_ff <= '0;
      end else begin
         if (cell_we) begin
            valid_ff[cell_addr(wr_r, wr_c)] <= 1'b1;
         end
         if (cmd.load_req || cmd.abort) begin
            sp_ff <= '0;
         end else if (cmd.seed_wr) begin
            sp_ff <= SPW'(1);
         end else if (cmd.pop) begin
            sp_ff <= sp_dec;
         end else if (push_ok && sp_ff != SP_FULL) begin
            sp_ff <= sp_ff + 1'b1;
         end
         if (cmd.nb_clr) begin
            nb_ff <= '0;
         end else if (cmd.nb_inc) begin
            nb_ff <= nb_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
         pops_ff <= '0;
         changed_ff <= '0;
         ovf_ff <= 1'b0;
      end
      if (cmd.cell_rd) begin
         rd_valid_ff <= valid_ff[cell_addr(rd_r, rd_c)];
         rd_r_ff <= rd_r;
         rd_c_ff <= rd_c;
      end
      if (cmd.pop) begin
         pops_ff <= pops_ff + 1'b1;
      end
      if (cmd.abort || (push_ok && sp_ff == SP_FULL)) begin
         ovf_ff <= 1'b1;
      end
      if (cmd.load_cur) begin
         cur_r_ff <= stk_q[2*CW-1:CW];
         cur_c_ff <= stk_q[CW-1:0];
      end
      if (cmd.cap_own) begin
         own_top_ff <= view.top;
         own_right_ff <= view.right;
         own_dist_ff <= view.distance;
         mn_ff <= mfdu_pkg::DIST_MAX;
         open_ff <= 1'b0;
      end
      if (cmd.cap_nb && nb_open) begin
         open_ff <= 1'b1;
         if (view.distance < mn_ff) begin
            mn_ff <= view.distance;
         end
      end
      if (cmd.upd_wr && changed_ff != mfdu_pkg::CHG_MAX) begin
         changed_ff <= changed_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         if (sts.oob) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.cell_dist <= view.distance;
            rsp_ff.cell_top <= view.top;
            rsp_ff.cell_right <= view.right;
            rsp_ff.cells_changed <= changed_ff;
            rsp_ff.overflow <= ovf_ff;
         end
      end
   end

   always_comb begin
      sts.sp_zero = (sp_ff == '0);
      sts.pop_limit = (pops_ff >= mfdu_pkg::FLOOD_POP_LIMIT);
      sts.cur_centre = is_centre(cur_r_ff, cur_c_ff);
      sts.nb_last = (nb_ff == mfdu_pkg::NB_LEFT);
      sts.upd_needed = open_ff && (nv != own_dist_ff);
      sts.mode = req_ff.mode;
      sts.oob = ({1'b0, req_ff.row} >= SIDE) || ({1'b0, req_ff.column} >= SIDE);
      sts.rsp_busy = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/core/maze_floodfill_distance_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_floodfill_distance_update
// Maze map keeper running a stack-based modified flood fill on wall updates.
// ----------------------------------------------------------------------------
// Requests arrive on req_ (valid/ready): mode 0 ORs wall bits into one cell
// and reflows distances from it; mode 1 reads one cell. Every request gives
// exactly one response on rsp_ (valid/ready) holding the cell's distance and
// walls, the count of distance rewrites, and overflow (stack full or pop cap).
// A read issues the map read, then loads the response register once it is
// free. A wall update seeds the cell, then per popped cell checks for the
// centre and, for any other, fetches the cell and its four neighbours one by
// one, as the map memory has one read port; each rewrite pushes its neighbours
// one per cycle. The next request can be taken in the cycle rsp_valid rises.
// One request is in flight at a time; req_ready is high while idle, also
// while an earlier response waits. A stalled receiver holds the finished
// response in the output register, and the next one waits behind it.
// Reset restores the initial map at once (valid bit per cell, unwritten
// cells read as the initial value), empties the stack and drops any response.
// ----------------------------------------------------------------------------
`include "maze_floodfill_distance_update_assert.svh"

module maze_floodfill_distance_update #(
   parameter int MAZE_SIDE = 16,
   parameter int STACK_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mfdu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mfdu_pkg::rsp_type rsp_data
);

   mfdu_pkg::cmd_type cmd;
   mfdu_pkg::sts_type sts;

   mfdu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   mfdu_dp #(.MAZE_SIDE(MAZE_SIDE), .STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   `MFDU_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `MFDU_ASSERT_SAME(a_pop_not_empty, cmd.pop, !sts.sp_zero)
   `MFDU_ASSERT_SAME(a_no_rsp_overwrite, cmd.rsp_load, !rsp_valid)

endmodule
